// ===== rtl/bfsa_pkg.sv =====
package bfsa_pkg;

  // Request opcodes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;
  localparam logic [1:0] OP_FIND  = 2'd3;

  // Configuration register indexes
  localparam logic REG_BITS_IN_USE = 1'b0;

  localparam logic [10:0] BITS_IN_USE_RESET = 11'd1024;
  localparam logic [31:0] FULL_WORD          = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] bit_index;
  } req_t;

  typedef struct packed {
    logic       bit_value;
    logic       found;
    logic [9:0] free_index;
  } rsp_t;

endpackage

// ===== rtl/bitmap_free_slot_allocator.sv =====
// Bitmap slot allocator: one request at a time (set, clear, test a bit, or find the lowest
// clear bit among the first bits_in_use positions). The bitmap lives in a synchronous RAM
// with registered reads, of 32-bit words with a valid bit per word, so it reads as all free
// straight after reset with no clearing pass. Set, clear and test do one RAM read; set and
// clear then modify the word and write it back. A find reads one word per cycle, pipelined,
// checking words in order until a clear bit turns up or the searched span ends. Out-of-range
// set/clear/test and a find over zero bits answer without a RAM read. A new request is taken
// once the previous result beat has left the output register. Register bits_in_use sits at
// byte address 0 of the APB port.
module bitmap_free_slot_allocator #(
  parameter int NUM_BITS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bfsa_pkg::req_t   in_beat_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bfsa_pkg::rsp_t   out_beat_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfsa_pkg::*;

  // Only the first 1024 positions can be addressed, so at most 32 words are ever used
  localparam int NumWords = (NUM_BITS + 31) / 32;
  localparam int MemDepth = (NumWords < 32) ? NumWords : 32;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int NumSpan  = (NUM_BITS < 1024) ? NUM_BITS : 1024;
  localparam logic [10:0] SpanBits = 11'(NumSpan);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      op_q, op_d;
  logic [9:0]      idx_q, idx_d;
  logic [4:0]      chk_q, chk_d;
  logic [10:0]     limit_q, limit_d;
  logic [10:0]     bits_in_use_q;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic [31:0]     mem [2**AddrW];
  logic [2**AddrW-1:0] vld_q;
  logic [31:0]     rdata_q;
  logic            rvalid_q;
  logic            rd_en;
  logic [AddrW-1:0] rd_addr;
  logic            mem_we;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]     wr_data;

  logic            in_fire;
  logic            in_range;
  logic [10:0]     lim_new;
  logic [31:0]     word;
  logic [10:0]     remaining;
  logic [10:0]     next_base;
  logic [31:0]     span_mask;
  logic [31:0]     free_bits;
  logic [4:0]      chk_next;

  // Lowest set bit of a word
  function automatic logic [4:0] lowest_one(input logic [31:0] v);
    logic [4:0] pos;
    pos = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (v[b]) begin
        pos = 5'(b);
      end
    end
    return pos;
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BITS_IN_USE) ? {21'd0, bits_in_use_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= BITS_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BITS_IN_USE) begin
      bits_in_use_q <= pwdata[10:0];
    end
  end

  // Handshake
  assign in_stall_o  = !(state_q == ST_IDLE && !out_valid_q);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  assign in_range = {22'd0, in_beat_i.bit_index} < 32'(NUM_BITS);
  assign lim_new  = (bits_in_use_q > SpanBits) ? SpanBits : bits_in_use_q;

  // Word read back, free where never written
  assign word      = rvalid_q ? rdata_q : 32'd0;
  assign remaining = limit_q - {1'b0, chk_q, 5'd0};
  assign next_base = {6'({1'b0, chk_q} + 6'd1), 5'd0};
  assign span_mask = (remaining >= 11'd32) ? FULL_WORD : ~(FULL_WORD << remaining[4:0]);
  assign free_bits = ~word & span_mask;
  assign chk_next  = chk_q + 5'd1;

  // Next state, RAM access and result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    wr_addr     = idx_q[AddrW+4:5];
    wr_data     = word;

    // Drop the beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = in_beat_i.opcode;
          idx_d = in_beat_i.bit_index;
          out_d = '0;
          if (in_beat_i.opcode == OP_FIND) begin
            limit_d = lim_new;
            chk_d   = 5'd0;
            if (lim_new == 11'd0) begin
              out_valid_d = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_SCAN;
            end
          end else if (in_range) begin
            rd_en   = 1'b1;
            rd_addr = in_beat_i.bit_index[AddrW+4:5];
            state_d = ST_ACCESS;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_ACCESS: begin
        out_d       = '0;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
        case (op_q)
          OP_SET: begin
            mem_we  = 1'b1;
            wr_data = word | (32'd1 << idx_q[4:0]);
          end
          OP_CLEAR: begin
            mem_we  = 1'b1;
            wr_data = word & ~(32'd1 << idx_q[4:0]);
          end
          OP_TEST: begin
            out_d.bit_value = word[idx_q[4:0]];
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        // Read the following word while this one is checked
        rd_en   = 1'b1;
        rd_addr = chk_next[AddrW-1:0];
        if (|free_bits) begin
          out_d.found      = 1'b1;
          out_d.free_index = {chk_q, lowest_one(free_bits)};
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end else if (next_base >= limit_q) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          chk_d = chk_next;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      op_q        <= OP_SET;
      idx_q       <= '0;
      chk_q       <= '0;
      limit_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      limit_q     <= limit_d;
    end
  end

  // Bitmap RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Word valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= vld_q[rd_addr];
      end
    end
  end

`ifndef SYNTHESIS
  a_scan_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !out_valid_q)
    else $error("result pending during a find");

  a_write_in_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_ACCESS && (op_q == OP_SET || op_q == OP_CLEAR)))
    else $error("bitmap written outside set or clear");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.found) |-> out_beat_o.free_index == 10'd0)
    else $error("free index without found");

  a_found_no_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.found) |-> !out_beat_o.bit_value)
    else $error("bit value set on a find result");
`endif

endmodule

// ===== tb/tb_bitmap_free_slot_allocator.sv =====
`timescale 1ns / 1ps

module tb_bitmap_free_slot_allocator;
  import bfsa_pkg::*;

  localparam int NUM_BITS        = 1024;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int NUM_PHASES      = 10;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 40;
  localparam logic [2:0] SPAN_ADDR = {REG_BITS_IN_USE, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    req_t        req;
    logic        typed;
    rsp_t        rsp;
    logic [10:0] span;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  req_t        in_beat_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_beat_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the bitmap and the search span
  logic [NUM_BITS-1:0] shadow_used;
  logic [10:0]         shadow_span;

  rsp_t      expected_rsps[$];
  stim_row_t stim_rows[$];

  int errors      = 0;
  int rsp_count   = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int n_items     = 0;
  int n_finds     = 0;
  int n_found     = 0;
  int n_exhausted = 0;
  int n_settings  = 0;

  bitmap_free_slot_allocator #(
    .NUM_BITS(NUM_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Positions searched by a find, clamped to the store
  function automatic int search_limit();
    return (shadow_span > NUM_BITS) ? NUM_BITS : int'(shadow_span);
  endfunction

  // Lowest clear position below limit, or -1 when all are set
  function automatic int lowest_free(input int limit);
    int where;
    where = -1;
    for (int p = limit - 1; p >= 0; p--) begin
      if (!shadow_used[p]) where = p;
    end
    return where;
  endfunction

  // Apply one request to the shadow bitmap and work out its response
  function automatic rsp_t predict_response(input req_t r);
    rsp_t p;
    int   where;
    p = '0;
    case (r.opcode)
      OP_SET:   shadow_used[r.bit_index] = 1'b1;
      OP_CLEAR: shadow_used[r.bit_index] = 1'b0;
      OP_TEST:  p.bit_value = shadow_used[r.bit_index];
      default: begin
        where = lowest_free(search_limit());
        if (where >= 0) begin
          p.found      = 1'b1;
          p.free_index = where[9:0];
        end
      end
    endcase
    return p;
  endfunction

  // Mostly allocator-like traffic within the span, with some full-range noise
  function automatic req_t next_random_req();
    req_t r;
    int   lim;
    int   span;
    int   pick;
    int   where;
    lim  = search_limit();
    span = (lim == 0) ? 1 : lim;
    pick = $urandom_range(0, 99);
    r.opcode    = OP_TEST;
    r.bit_index = 10'($urandom_range(0, span - 1));
    if (pick < 30) begin
      r.opcode = OP_FIND;
    end else if (pick < 50) begin
      r.opcode = OP_SET;
      where = lowest_free(lim);
      if (where >= 0) r.bit_index = where[9:0];
    end else if (pick < 65) begin
      r.opcode = OP_SET;
    end else if (pick < 75) begin
      r.opcode = OP_CLEAR;
    end else if (pick < 85) begin
      r.opcode = OP_TEST;
    end else begin
      r.opcode    = 2'($urandom_range(0, 3));
      r.bit_index = 10'($urandom_range(0, NUM_BITS - 1));
    end
    return r;
  endfunction

  function automatic void add_req(input logic [1:0] op, input logic [9:0] idx,
                                  input logic typed, input logic bv, input logic fnd,
                                  input logic [9:0] fi);
    stim_row_t row;
    row                = '0;
    row.kind           = ROW_ITEM;
    row.req.opcode     = op;
    row.req.bit_index  = idx;
    row.typed          = typed;
    row.rsp.bit_value  = bv;
    row.rsp.found      = fnd;
    row.rsp.free_index = fi;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [10:0] span);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.span = span;
    stim_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      errors++;
    end
  endtask

  // Insert a random gap between bursts of beats
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // Offer one request beat and hold it until accepted
  task automatic send_item(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t p;
    in_valid_i <= 1'b1;
    in_beat_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = predict_response(r);
    expected_rsps.push_back(typed ? typed_rsp : p);
    n_items++;
    if (r.opcode == OP_FIND) begin
      n_finds++;
      if (p.found) n_found++;
      else n_exhausted++;
    end
  endtask

  // Drain the block, then write the span register and read it back
  task automatic program_span(input logic [10:0] value);
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPAN_ADDR;
    pwdata  <= {21'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow_span = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("bits_in_use read-back", int'(shadow_span), int'(prdata[10:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                 $time, out_beat_o);
        errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        check_field("bit_value", int'(exp_rsp.bit_value), int'(out_beat_o.bit_value));
        check_field("found", int'(exp_rsp.found), int'(out_beat_o.found));
        check_field("free_index", int'(exp_rsp.free_index), int'(out_beat_o.free_index));
      end
      rsp_count++;
    end
  end

  // Drop the run when no beat or register access moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("bitmap_free_slot_allocator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver stall pattern, with two long hold-offs to back the block up
  initial begin
    int mode;
    int seg;
    int holds_done;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < 2 && rsp_count >= ((holds_done == 0) ? 200 : 900)) begin
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 120);
        repeat (seg) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            2:       out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [10:0] span_plan [NUM_PHASES];
    shadow_used = '0;
    shadow_span = BITS_IN_USE_RESET;

    // Directed table: empty map, both ends of the index, every opcode
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b1, 10'd0);
    add_req(OP_TEST,  10'd1023, 1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_SET,   10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_SET,   10'd1023, 1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_TEST,  10'd1023, 1'b1, 1'b1, 1'b0, 10'd0);
    add_req(OP_TEST,  10'd0,    1'b1, 1'b1, 1'b0, 10'd0);
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b1, 10'd1);
    add_req(OP_FIND,  10'd1023, 1'b1, 1'b0, 1'b1, 10'd1);
    add_req(OP_CLEAR, 10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b1, 10'd0);
    add_req(OP_SET,   10'h2AA,  1'b0, 1'b0, 1'b0, 10'd0);
    add_req(OP_SET,   10'h155,  1'b0, 1'b0, 1'b0, 10'd0);
    add_req(OP_TEST,  10'h155,  1'b0, 1'b0, 1'b0, 10'd0);
    // every searched bit set
    add_cfg(11'd2);
    add_req(OP_SET,   10'd1,    1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_SET,   10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    // zero search length
    add_cfg(11'd0);
    add_req(OP_CLEAR, 10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0);
    // search length beyond the store
    add_cfg(11'd2047);
    add_req(OP_FIND,  10'd0,    1'b1, 1'b0, 1'b1, 10'd0);
    add_cfg(11'd1024);
    add_req(OP_CLEAR, 10'd1023, 1'b0, 1'b0, 1'b0, 10'd0);
    add_req(OP_TEST,  10'd1023, 1'b0, 1'b0, 1'b0, 10'd0);
    add_req(OP_FIND,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0);

    // Small spans first so the map fills, then wide ones that search deep
    span_plan = '{11'd40, 11'd1, 11'd32, 11'd64, 11'd0, 11'd2047, 11'd96, 11'd1024,
                  11'd0, 11'd1023};
    span_plan[8] = 11'($urandom_range(0, 2047));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        program_span(stim_rows[i].span);
      end else begin
        pace_sender();
        send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
      end
    end

    // Random phases, one span setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_span(span_plan[ph]);
      repeat (ITEMS_PER_PHASE) begin
        pace_sender();
        send_item(next_random_req(), 1'b0, '0);
      end
    end

    // Drain outstanding results, then allow stray beats to show up
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests over %0d span settings; %0d finds, %0d hit, %0d exhausted",
             n_items, n_settings, n_finds, n_found, n_exhausted);
    $display("Receiver hold-offs backed the block up; %0d result beats checked", rsp_count);
    if (errors == 0) begin
      $display("bitmap_free_slot_allocator verification clean");
    end else begin
      $display("bitmap_free_slot_allocator verification failed");
    end
    $finish;
  end

endmodule
